// ----- rtl/core/cmab_pkg.sv -----
// ----------------------------------------------------------------------------
// cmab_pkg
// Shared types and constants for the centered moving average band-pass block.
// ----------------------------------------------------------------------------
package cmab_pkg;

  localparam int SW    = 16;  // sample width
  localparam int WW    = 5;   // window register width
  localparam int HW    = 4;   // half window width
  localparam int SUMW  = 21;  // window sum width
  localparam int PW    = 5;   // pending counter width
  localparam int SEENW = 6;   // sample counter width
  localparam int DEPTH = 32;  // history ring depth
  localparam int AW    = 5;   // ring address width
  localparam int RELW  = 8;   // relative offset width
  localparam int DIVW  = 20;  // divider magnitude width
  localparam int QW    = 17;  // signed quotient width

  localparam logic [SEENW-1:0] SEEN_MAX = '1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_LOW_WINDOW  = 1'b0,
    REG_HIGH_WINDOW = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S1_CHK,
    ST_S1_RD,
    ST_S1_ADD,
    ST_S1_DIV,
    ST_S1_WAIT,
    ST_S2_CHK,
    ST_S2_CRD,
    ST_S2_CLD,
    ST_S2_RD,
    ST_S2_ADD,
    ST_S2_DIV,
    ST_S2_WAIT,
    ST_S2_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // store accepted sample
    logic stage2;    // stage-two addressing and window
    logic clr;       // clear accumulator and term index
    logic rd;        // issue history read
    logic ctr;       // read the center entry
    logic add;       // accumulate read data
    logic div_go;    // start divider
    logic s1_wr;     // commit stage-one mean
    logic ctr_ld;    // latch center value
    logic s2_fin;    // form band-passed result
    logic emit;      // load output register
    logic wave_end;  // end of input processing
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic s1_due;
    logic s2_due;
    logic win_end;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/cmab_div.sv -----
// ----------------------------------------------------------------------------
// cmab_div
// Radix-2 restoring divider by a small odd window, rounded half away from zero.
// ----------------------------------------------------------------------------
module cmab_div import cmab_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SUMW-1:0] dividend,
  input  logic        [WW-1:0]   divisor,
  output logic                   done,
  output logic signed [QW-1:0]   quotient
);

  localparam logic [4:0] DIV_LAST = 5'(DIVW - 1);

  logic            busy;
  logic [4:0]      cnt;
  logic [WW-1:0]   rem;
  logic [DIVW-1:0] quo;
  logic            neg;
  logic [SUMW-1:0] mag;
  logic [WW:0]     trial;
  logic            ge;
  logic [WW:0]     diff;

  // magnitude and one restoring step
  always_comb begin
    mag   = dividend[SUMW-1] ? 21'(-dividend) : dividend;
    trial = {rem, quo[DIVW-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUMW-1];
      rem <= '0;
      quo <= mag[DIVW-1:0] + {{(DIVW-HW){1'b0}}, divisor[WW-1:1]};
    end else if (busy) begin
      rem <= ge ? diff[WW-1:0] : trial[WW-1:0];
      quo <= {quo[DIVW-2:0], ge};
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo[SW-1:0]}) : $signed({1'b0, quo[SW-1:0]});

endmodule

// ----- rtl/core/cmab_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmab_ctrl
// Sequencer: stage-one mean per pending input, then stage-two results.
// ----------------------------------------------------------------------------
module cmab_ctrl import cmab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_S1_CHK;
        end
      end
      ST_S1_CHK: begin
        if (stat.s1_due) begin
          cmd.clr    = 1'b1;
          state_next = ST_S1_RD;
        end else begin
          cmd.wave_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_S1_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_S1_ADD;
      end
      ST_S1_ADD: begin
        cmd.add    = 1'b1;
        state_next = stat.win_end ? ST_S1_DIV : ST_S1_RD;
      end
      ST_S1_DIV: begin
        cmd.div_go = 1'b1;
        state_next = ST_S1_WAIT;
      end
      ST_S1_WAIT: begin
        if (stat.div_done) begin
          cmd.s1_wr  = 1'b1;
          state_next = ST_S2_CHK;
        end
      end
      ST_S2_CHK: begin
        cmd.stage2 = 1'b1;
        if (stat.s2_due) begin
          cmd.clr    = 1'b1;
          state_next = ST_S2_CRD;
        end else begin
          state_next = ST_S1_CHK;
        end
      end
      ST_S2_CRD: begin
        cmd.stage2 = 1'b1;
        cmd.rd     = 1'b1;
        cmd.ctr    = 1'b1;
        state_next = ST_S2_CLD;
      end
      ST_S2_CLD: begin
        cmd.stage2 = 1'b1;
        cmd.ctr_ld = 1'b1;
        state_next = ST_S2_RD;
      end
      ST_S2_RD: begin
        cmd.stage2 = 1'b1;
        cmd.rd     = 1'b1;
        state_next = ST_S2_ADD;
      end
      ST_S2_ADD: begin
        cmd.stage2 = 1'b1;
        cmd.add    = 1'b1;
        state_next = stat.win_end ? ST_S2_DIV : ST_S2_RD;
      end
      ST_S2_DIV: begin
        cmd.stage2 = 1'b1;
        cmd.div_go = 1'b1;
        state_next = ST_S2_WAIT;
      end
      ST_S2_WAIT: begin
        cmd.stage2 = 1'b1;
        if (stat.div_done) begin
          cmd.s2_fin = 1'b1;
          state_next = ST_S2_EMIT;
        end
      end
      ST_S2_EMIT: begin
        cmd.stage2 = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_S2_CHK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/cmab_dp.sv -----
// ----------------------------------------------------------------------------
// cmab_dp
// Datapath: history rings, window accumulator, divider, output register.
// ----------------------------------------------------------------------------
module cmab_dp import cmab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic signed [SW-1:0] sample_in,
  input  logic                 last_in,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [WW-1:0]        cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] sample_out,
  output logic                 last_out
);

  logic [SW-1:0]          in_mem [DEPTH];
  logic [SW-1:0]          sm_mem [DEPTH];
  logic [WW-1:0]          smooth_len;
  logic [WW-1:0]          wide_len;
  logic [AW-1:0]          in_wr;
  logic [AW-1:0]          sm_wr;
  logic [SEENW-1:0]       seen;
  logic [PW-1:0]          pending_in;
  logic [PW-1:0]          pending_sm;
  logic                   last_flag;
  logic [AW-1:0]          j;
  logic signed [SUMW-1:0] acc;
  logic signed [SW-1:0]   rdata;
  logic signed [SW-1:0]   centre;
  logic signed [SW-1:0]   result;
  logic                   result_last;
  logic                   div_done;
  logic signed [QW-1:0]   quotient;

  logic [HW-1:0]          h;
  logic [PW-1:0]          p;
  logic [AW-1:0]          wr;
  logic signed [RELW-1:0] rel;
  logic signed [RELW-1:0] lo;
  logic signed [RELW-1:0] rel_c;
  logic [RELW-1:0]        slot_full;
  logic [AW-1:0]          slot;
  logic signed [SW+1:0]   diff;

  // configuration: even lengths round up to the next odd value
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_len <= WW'(1);
      wide_len   <= WW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_WINDOW:  smooth_len <= cfg_data | WW'(1);
        REG_HIGH_WINDOW: wide_len   <= cfg_data | WW'(1);
        default: ;
      endcase
    end
  end

  // history address: offset from newest, clamped to the newest entry and to the waveform start
  always_comb begin
    h  = cmd.stage2 ? wide_len[WW-1:1] : smooth_len[WW-1:1];
    p  = cmd.stage2 ? pending_sm : pending_in;
    wr = cmd.stage2 ? sm_wr : in_wr;
    lo = RELW'(1) - $signed({2'b0, seen});
    if (cmd.stage2) begin
      lo = lo + $signed({3'b0, pending_in});
    end
    if (cmd.ctr) begin
      rel = RELW'(1) - $signed({3'b0, p});
    end else begin
      rel = $signed({3'b0, j}) - $signed({4'b0, h}) - $signed({3'b0, p}) + RELW'(1);
    end
    rel_c = rel;
    if (rel_c > 0) begin
      rel_c = '0;
    end
    if (rel_c < lo) begin
      rel_c = lo;
    end
    slot_full = {3'b0, wr} + rel_c - RELW'(1);
    slot      = slot_full[AW-1:0];
  end

  // history rings
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_mem[in_wr] <= sample_in;
    end
    if (cmd.s1_wr) begin
      sm_mem[sm_wr] <= quotient[SW-1:0];
    end
    if (cmd.rd) begin
      rdata <= cmd.stage2 ? sm_mem[slot] : in_mem[slot];
    end
  end

  // counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_wr      <= '0;
      sm_wr      <= '0;
      seen       <= '0;
      pending_in <= '0;
      pending_sm <= '0;
      last_flag  <= 1'b0;
    end else begin
      if (cmd.take) begin
        in_wr      <= in_wr + AW'(1);
        pending_in <= pending_in + PW'(1);
        last_flag  <= last_in;
        if (seen != SEEN_MAX) begin
          seen <= seen + SEENW'(1);
        end
      end
      if (cmd.s1_wr) begin
        sm_wr      <= sm_wr + AW'(1);
        pending_in <= pending_in - PW'(1);
        pending_sm <= pending_sm + PW'(1);
      end
      if (cmd.s2_fin) begin
        pending_sm <= pending_sm - PW'(1);
      end
      if (cmd.wave_end && last_flag) begin
        seen       <= '0;
        pending_in <= '0;
        pending_sm <= '0;
      end
    end
  end

  // window accumulator
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      acc <= '0;
      j   <= '0;
    end else if (cmd.add) begin
      acc <= acc + SUMW'(rdata);
      j   <= j + AW'(1);
    end
  end

  cmab_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (acc),
    .divisor  (cmd.stage2 ? wide_len : smooth_len),
    .done     (div_done),
    .quotient (quotient)
  );

  // stage-two difference with saturation
  always_comb begin
    diff = (SW+2)'(centre) - (SW+2)'(quotient);
  end

  always_ff @(posedge clk) begin
    if (cmd.ctr_ld) begin
      centre <= rdata;
    end
    if (cmd.s2_fin) begin
      if (diff > $signed((SW+2)'(16'sh7fff))) begin
        result <= 16'sh7fff;
      end else if (diff < $signed((SW+2)'(-17'sd32768))) begin
        result <= 16'sh8000;
      end else begin
        result <= diff[SW-1:0];
      end
      result_last <= last_flag && (pending_in == '0) && (pending_sm == PW'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= result;
      last_out   <= result_last;
    end
  end

  // status
  always_comb begin
    stat.s1_due   = (pending_in > {1'b0, smooth_len[WW-1:1]}) ||
                    (last_flag && (pending_in != '0));
    stat.s2_due   = (pending_sm > {1'b0, wide_len[WW-1:1]}) ||
                    (last_flag && (pending_in == '0) && (pending_sm != '0));
    stat.win_end  = j == {h, 1'b0};
    stat.div_done = div_done;
    stat.out_free = !out_valid || out_ready;
  end

  // checks
  a_pend_in_bound: assert property (@(posedge clk) disable iff (rst)
    pending_in <= PW'(16)) else $error("pending input count out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready)) else $error("output overwritten");

  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.s1_wr || cmd.s2_fin) |-> div_done) else $error("commit before divide done");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.wave_end && last_flag) |=> (pending_in == '0 && pending_sm == '0))
    else $error("flush left pending items");

endmodule

// ----- rtl/core/centered_moving_average_bandpass_top.sv -----
// ----------------------------------------------------------------------------
// centered_moving_average_bandpass_top
// Two-stage centered moving average band-pass filter over framed samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time; in_ready is high only while the sequencer is
// idle, and configuration writes are accepted only then as well. Each
// stage-one mean and each result is formed by a one-read-per-term history
// loop over its window and the 20-step serial divider, and a result may also
// wait on an output stall. A sample that completes no stage-one mean returns
// the sequencer straight to idle; the last sample of a waveform also flushes
// up to 31 results.
// Results wait in an output register, so a stalled consumer only holds the
// sequencer at the point of the next result.
module centered_moving_average_bandpass_top import cmab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [SW-1:0] sample_in,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] sample_out,
  output logic                 last_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [WW-1:0]        cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // window writes only between samples
  assign cfg_ready = in_ready;

  cmab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cmab_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

endmodule
